// ----- hw/rtl/ccl_pkg.sv -----
// Shared types, constants and helper functions of the color cube pixel classifier.
package ccl_pkg;

    // Cube geometry and level range.
    localparam int NODES       = 16;
    localparam int LEVELS      = 256;
    localparam int NODE_BITS   = 4;
    localparam int LEVEL_BITS  = 8;
    localparam int INDEX_BITS  = 3 * NODE_BITS;
    localparam int TABLE_DEPTH = NODES * NODES * NODES;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(LEVELS - 1);
    localparam logic [NODE_BITS-1:0]  NODE_MAX  = NODE_BITS'(NODES - 1);

    // Pipeline depth: input register, five normalize stages, node stage, table read.
    localparam int NUM_STAGES = 8;

    // Configuration port geometry.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_DYNAMIC_MODE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_SPAN   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LOW     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HIGH    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROUND_BIAS   = 3'd5;

    // Item operation codes.
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [INDEX_BITS-1:0] entry_index;
        logic [7:0]            distance_value;
        logic [7:0]            threshold_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] distance;
        logic [7:0] thresholded;
    } t_out_item;

    // Fields of an item that ride alongside the channel datapath.
    typedef struct packed {
        logic                  op;
        logic [INDEX_BITS-1:0] entry_index;
        logic [7:0]            distance_value;
        logic [7:0]            threshold_value;
    } t_side;

    typedef struct packed {
        logic                  dynamic_mode;
        logic [LEVEL_BITS-1:0] min_level;
        logic [LEVEL_BITS-1:0] level_span;
        logic [LEVEL_BITS-1:0] clip_low;
        logic [LEVEL_BITS-1:0] clip_high;
        logic [NODE_BITS-1:0]  round_bias;
    } t_cfg;

    // Per-stage advance enables of the pipeline.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    // One restoring division step: returns the quotient bit over the new remainder.
    function automatic logic [LEVEL_BITS:0] div_step(input logic [LEVEL_BITS-1:0] rem,
                                                     input logic                  nbit,
                                                     input logic [LEVEL_BITS-1:0] den);
        logic [LEVEL_BITS:0] trial;
        logic [LEVEL_BITS:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[LEVEL_BITS-1:0]};
        end else begin
            return {1'b0, trial[LEVEL_BITS-1:0]};
        end
    endfunction

endpackage

// ----- hw/rtl/ccl_chan_norm.sv -----
// One channel: level normalization by a pipelined divider and node index saturation.
module ccl_chan_norm (
    input  logic                                i_clk,
    input  ccl_pkg::t_pipe_ctl                  i_ctl,
    input  ccl_pkg::t_cfg                       i_cfg,
    input  logic [ccl_pkg::LEVEL_BITS-1:0]      i_chan,
    output logic [ccl_pkg::NODE_BITS-1:0]       o_node
);

    localparam int LB = ccl_pkg::LEVEL_BITS;
    localparam int FIRST_DIV = 2;
    localparam int LAST_DIV  = 5;

    // Stage 1: offset from the base, divisor, early zero and saturate decisions.
    logic [LB-1:0]   base;
    logic [LB-1:0]   diff;
    logic            below;
    logic [LB-1:0]   n_den1;
    logic            n_sat1;
    logic [2*LB-1:0] n_num1;

    logic [2*LB-1:0] r_num1;
    logic [LB-1:0]   r_den1;
    logic            r_zero1;
    logic            r_sat1;

    always_comb begin
        base   = i_cfg.dynamic_mode ? i_cfg.min_level : i_cfg.clip_low;
        below  = i_chan < base;
        diff   = i_chan - base;
        n_den1 = i_cfg.dynamic_mode ? i_cfg.level_span : (i_cfg.clip_high - i_cfg.clip_low);
        n_sat1 = i_cfg.dynamic_mode ? (i_cfg.level_span == '0) : (i_chan >= i_cfg.clip_high);
        // 255 * diff as a shift and a subtract.
        n_num1 = {diff, {LB{1'b0}}} - {{LB{1'b0}}, diff};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_num1  <= n_num1;
            r_den1  <= n_den1;
            r_zero1 <= below;
            r_sat1  <= n_sat1;
        end
    end

    // Divider stages, two quotient bits per stage.
    logic [LB-1:0] r_rem  [FIRST_DIV:LAST_DIV];
    logic [LB-1:0] r_q    [FIRST_DIV:LAST_DIV];
    logic [LB-1:0] r_nlo  [FIRST_DIV:LAST_DIV];
    logic [LB-1:0] r_den  [FIRST_DIV:LAST_DIV];
    logic          r_zero [FIRST_DIV:LAST_DIV];
    logic          r_sat  [FIRST_DIV:LAST_DIV];

    // Stage 2 also flags a quotient above the level range.
    logic          ovf2;
    logic [LB:0]   step2a;
    logic [LB:0]   step2b;

    always_comb begin
        ovf2   = r_num1[2*LB-1:LB] >= r_den1;
        step2a = ccl_pkg::div_step(r_num1[2*LB-1:LB], r_num1[LB-1], r_den1);
        step2b = ccl_pkg::div_step(step2a[LB-1:0], r_num1[LB-2], r_den1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[FIRST_DIV]) begin
            r_rem[FIRST_DIV]  <= step2b[LB-1:0];
            r_q[FIRST_DIV]    <= {step2a[LB], step2b[LB], {(LB-2){1'b0}}};
            r_nlo[FIRST_DIV]  <= r_num1[LB-1:0];
            r_den[FIRST_DIV]  <= r_den1;
            r_zero[FIRST_DIV] <= r_zero1;
            r_sat[FIRST_DIV]  <= r_sat1 | ovf2;
        end
    end

    for (genvar g = FIRST_DIV + 1; g <= LAST_DIV; g++) begin : g_div
        localparam int HI = 2 * (LAST_DIV - g) + 1;
        logic [LB:0]   step_a;
        logic [LB:0]   step_b;
        logic [LB-1:0] q_next;

        always_comb begin
            step_a = ccl_pkg::div_step(r_rem[g-1], r_nlo[g-1][HI], r_den[g-1]);
            step_b = ccl_pkg::div_step(step_a[LB-1:0], r_nlo[g-1][HI-1], r_den[g-1]);
            q_next = r_q[g-1];
            q_next[HI]   = step_a[LB];
            q_next[HI-1] = step_b[LB];
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en[g]) begin
                r_rem[g]  <= step_b[LB-1:0];
                r_q[g]    <= q_next;
                r_nlo[g]  <= r_nlo[g-1];
                r_den[g]  <= r_den[g-1];
                r_zero[g] <= r_zero[g-1];
                r_sat[g]  <= r_sat[g-1];
            end
        end
    end

    // Stage 6: final level, rounding offset and node saturation.
    logic [LB-1:0]                  level;
    logic [LB:0]                    level_sum;
    logic [ccl_pkg::NODE_BITS-1:0]  n_node;
    logic [ccl_pkg::NODE_BITS-1:0]  r_node;

    always_comb begin
        if (r_zero[LAST_DIV]) begin
            level = '0;
        end else if (r_sat[LAST_DIV]) begin
            level = ccl_pkg::LEVEL_MAX;
        end else begin
            level = r_q[LAST_DIV];
        end
        level_sum = {1'b0, level} + (LB+1)'(i_cfg.round_bias);
        n_node    = level_sum[LB] ? ccl_pkg::NODE_MAX
                                  : level_sum[LB-1 -: ccl_pkg::NODE_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[LAST_DIV+1]) begin
            r_node <= n_node;
        end
    end

    assign o_node = r_node;

endmodule

// ----- hw/rtl/ccl_table.sv -----
// Distance and threshold table memory with its registered read port.
module ccl_table (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  ccl_pkg::t_side                  i_side,
    input  logic [ccl_pkg::INDEX_BITS-1:0]  i_rd_index,
    output ccl_pkg::t_out_item              o_data
);

    // Both tables share one entry: distance in the upper byte, threshold in the lower.
    ccl_pkg::t_out_item mem [ccl_pkg::TABLE_DEPTH];
    ccl_pkg::t_out_item r_rd;

    // A write item loads one entry when it leaves the node stage.
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && (i_side.op == ccl_pkg::OP_WRITE)) begin
            mem[i_side.entry_index] <= {i_side.distance_value, i_side.threshold_value};
        end
    end

    // A classify item reads its entry into the output register; a stall holds it.
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && (i_side.op == ccl_pkg::OP_CLASSIFY)) begin
            r_rd <= mem[i_rd_index];
        end
    end

    assign o_data = r_rd;

endmodule

// ----- hw/rtl/color_cube_lut_pixel_classify.sv -----
// A classify result passes the input register, normalize stages, node stage and table read.
// Throughput: one item per cycle without output stalls; two quotient bits per divider stage.
// Write items update both tables when they reach the table stage and produce no result.
// Reset (synchronous, active low) empties the pipeline and restores the register defaults.
// The tables are not cleared by reset; an entry holds unknown data until it is written.
module color_cube_lut_pixel_classify (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ccl_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ccl_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [ccl_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [ccl_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int NS       = ccl_pkg::NUM_STAGES;
    localparam int NODE_STG = NS - 2;

    // Configuration registers.
    ccl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dynamic_mode <= 1'b0;
            r_cfg.min_level    <= 8'd0;
            r_cfg.level_span   <= 8'd255;
            r_cfg.clip_low     <= 8'd0;
            r_cfg.clip_high    <= 8'd255;
            r_cfg.round_bias   <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ccl_pkg::CFG_DYNAMIC_MODE: r_cfg.dynamic_mode <= i_cfg_data[0];
                ccl_pkg::CFG_MIN_LEVEL:    r_cfg.min_level    <= i_cfg_data;
                ccl_pkg::CFG_LEVEL_SPAN:   r_cfg.level_span   <= i_cfg_data;
                ccl_pkg::CFG_CLIP_LOW:     r_cfg.clip_low     <= i_cfg_data;
                ccl_pkg::CFG_CLIP_HIGH:    r_cfg.clip_high    <= i_cfg_data;
                ccl_pkg::CFG_ROUND_BIAS:   r_cfg.round_bias   <= i_cfg_data[ccl_pkg::NODE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage enables: a stage advances when it is empty or the stage after it advances.
    logic [NS-1:0]      r_v;
    ccl_pkg::t_pipe_ctl ctl;
    ccl_pkg::t_in_item  r_item0;
    ccl_pkg::t_side     r_side [1:NODE_STG];

    always_comb begin
        ctl.en[NS-1] = !r_v[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            ctl.en[k] = !r_v[k] || ctl.en[k+1];
        end
    end

    assign o_in_ready = ctl.en[0];

    // Valid bits travel with the data; a write item leaves no result behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ctl.en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NS - 1; k++) begin
                if (ctl.en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (ctl.en[NS-1]) begin
                r_v[NS-1] <= r_v[NS-2] && (r_side[NODE_STG].op == ccl_pkg::OP_CLASSIFY);
            end
        end
    end

    // Input register and the side fields that follow the channel datapath.
    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_item0 <= i_in_data;
        end
        if (ctl.en[1]) begin
            r_side[1] <= '{op:              r_item0.op,
                           entry_index:     r_item0.entry_index,
                           distance_value:  r_item0.distance_value,
                           threshold_value: r_item0.threshold_value};
        end
        for (int k = 2; k <= NODE_STG; k++) begin
            if (ctl.en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Per-channel normalization and node index.
    logic [ccl_pkg::NODE_BITS-1:0] node_r;
    logic [ccl_pkg::NODE_BITS-1:0] node_g;
    logic [ccl_pkg::NODE_BITS-1:0] node_b;

    ccl_chan_norm u_norm_r (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (r_cfg),
        .i_chan (r_item0.red),
        .o_node (node_r)
    );

    ccl_chan_norm u_norm_g (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (r_cfg),
        .i_chan (r_item0.green),
        .o_node (node_g)
    );

    ccl_chan_norm u_norm_b (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (r_cfg),
        .i_chan (r_item0.blue),
        .o_node (node_b)
    );

    // Table stage: red node is the most significant digit of the index.
    ccl_table u_table (
        .i_clk      (i_clk),
        .i_en       (ctl.en[NS-1]),
        .i_valid    (r_v[NS-2]),
        .i_side     (r_side[NODE_STG]),
        .i_rd_index ({node_r, node_g, node_b}),
        .o_data     (o_out_data)
    );

    assign o_out_valid = r_v[NS-1];

endmodule

// ----- hw/rtl/ccl_checker.sv -----
// Port-level assertions for the color cube pixel classifier and their bind.
module ccl_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input ccl_pkg::t_in_item                   i_in_data,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input ccl_pkg::t_out_item                  o_out_data
);

    logic pix_xfer;
    assign pix_xfer = i_in_valid && o_in_ready && (i_in_data.op == ccl_pkg::OP_CLASSIFY);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A held result keeps its data until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // With the output free the pipeline never holds off the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output side was free");

    // A pixel with a free output path arrives at the output.
    a_pix_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_xfer ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("pixel result missing after free-flowing latency");

endmodule

bind color_cube_lut_pixel_classify ccl_checker u_ccl_checker (.*);
